[design/chsq_pkg.sv]
// Shared types and constants for the chi-squared histogram distance core.
// No dependencies; every other design file refers to this package by scoped names.
package chsq_pkg;

    localparam int BIN_W             = 17;
    localparam int DIFF_W            = BIN_W + 1;
    localparam int DEN_W             = BIN_W + 1;
    localparam int SQ_W              = 2 * BIN_W + 1;
    localparam int OUT_W             = 32;
    localparam int SUM_WIDTH_DEFAULT = 32;

    // Bin value -1.0 in Q1.16, used as the missing-vector marker.
    localparam logic signed [BIN_W-1:0] SENTINEL_BIN = {1'b1, {(BIN_W-1){1'b0}}};

    // One pair in flight through the divider chain.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             sent;
        logic             neg;
        logic             zero;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [SQ_W-1:0]  work;
    } chsq_cell_t;

endpackage

[design/chsq_front.sv]
// Input stages: difference and sum of the two bins, then the square and the divisor magnitude.
// Depends on chsq_pkg; feeds the first divider cell.
module chsq_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [chsq_pkg::BIN_W-1:0]     first_bin,
    input  logic signed [chsq_pkg::BIN_W-1:0]     second_bin,
    input  logic                                  last_bin,
    output chsq_pkg::chsq_cell_t                  out
);

    logic                                 a_valid_reg;
    logic                                 a_last_reg;
    logic                                 a_sent_reg;
    logic signed [chsq_pkg::DIFF_W-1:0]   d_reg;
    logic signed [chsq_pkg::DIFF_W-1:0]   s_reg;
    chsq_pkg::chsq_cell_t                 b_reg;

    logic signed [chsq_pkg::DIFF_W-1:0]   a_ext;
    logic signed [chsq_pkg::DIFF_W-1:0]   b_ext;
    logic signed [2*chsq_pkg::DIFF_W-1:0] prod;
    logic        [chsq_pkg::DEN_W-1:0]    den_abs;

    assign a_ext   = chsq_pkg::DIFF_W'(first_bin);
    assign b_ext   = chsq_pkg::DIFF_W'(second_bin);
    assign prod    = d_reg * d_reg;
    // Magnitude of the sum; the most negative value still fits unsigned.
    assign den_abs = s_reg[chsq_pkg::DIFF_W-1] ? chsq_pkg::DEN_W'(-s_reg)
                                               : chsq_pkg::DEN_W'(s_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_reg.valid <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_reg.valid <= a_valid_reg;
        end
        if (en) begin
            a_last_reg <= last_bin;
            a_sent_reg <= (first_bin == chsq_pkg::SENTINEL_BIN) ||
                          (second_bin == chsq_pkg::SENTINEL_BIN);
            d_reg      <= a_ext - b_ext;
            s_reg      <= a_ext + b_ext;
            b_reg.last <= a_last_reg;
            b_reg.sent <= a_sent_reg;
            b_reg.neg  <= s_reg[chsq_pkg::DIFF_W-1];
            b_reg.zero <= (s_reg == '0);
            b_reg.den  <= den_abs;
            b_reg.rem  <= '0;
            b_reg.work <= prod[chsq_pkg::SQ_W-1:0];
        end
    end

    assign out = b_reg;

endmodule

[design/chsq_div_cell.sv]
// One restoring-division cell: brings down the next dividend bit and produces one quotient bit.
// Depends on chsq_pkg; cells are chained so each hands its pair to the next every cycle while en is high.
module chsq_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  chsq_pkg::chsq_cell_t in,
    output chsq_pkg::chsq_cell_t out
);

    chsq_pkg::chsq_cell_t         cell_reg;
    logic [chsq_pkg::DEN_W:0]     trial;
    logic                         fits;
    logic [chsq_pkg::DEN_W:0]     diff;

    // The dividend is shifted out of the top of work while quotient bits enter at the bottom.
    assign trial = {in.rem, in.work[chsq_pkg::SQ_W-1]};
    assign fits  = trial >= {1'b0, in.den};
    assign diff  = trial - {1'b0, in.den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= in.valid;
        end
        if (en) begin
            cell_reg.last <= in.last;
            cell_reg.sent <= in.sent;
            cell_reg.neg  <= in.neg;
            cell_reg.zero <= in.zero;
            cell_reg.den  <= in.den;
            cell_reg.rem  <= fits ? diff[chsq_pkg::DEN_W-1:0] : trial[chsq_pkg::DEN_W-1:0];
            cell_reg.work <= {in.work[chsq_pkg::SQ_W-2:0], fits};
        end
    end

    assign out = cell_reg;

endmodule

[design/chsq_accum.sv]
// Accumulator cell: signed add of each quotient with clamping, vector tracking and result register.
// Depends on chsq_pkg; takes the finished quotient from the last divider cell.
module chsq_accum #(
    parameter int SUM_WIDTH = chsq_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  chsq_pkg::chsq_cell_t         in,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [chsq_pkg::OUT_W-1:0]   m_distance,
    output logic                         m_features_missing,
    output logic                         m_saturated
);

    localparam int EW = ((SUM_WIDTH > chsq_pkg::SQ_W) ? SUM_WIDTH : chsq_pkg::SQ_W) + 1;

    logic [SUM_WIDTH-1:0]        sum_reg,  sum_next;
    logic                        at_first_reg, at_first_next;
    logic                        missing_reg,  missing_next;
    logic                        overflow_reg, overflow_next;
    logic                        m_valid_reg,  m_valid_next;
    logic [chsq_pkg::OUT_W-1:0]  m_distance_reg, m_distance_next;
    logic                        m_missing_reg,  m_missing_next;
    logic                        m_sat_reg,      m_sat_next;

    logic [EW-1:0]        sum_ext, q_ext, sum_max_ext, out_max_ext, add_v, sub_v, upd_ext;
    logic [SUM_WIDTH-1:0] sum_upd;
    logic                 ovf_upd;
    logic                 miss;
    logic                 fire;
    logic                 res_fire;

    assign fire        = en && in.valid;
    assign res_fire    = fire && in.last;
    assign sum_ext     = EW'(sum_reg);
    assign q_ext       = EW'(in.work);
    assign sum_max_ext = EW'({SUM_WIDTH{1'b1}});
    assign out_max_ext = EW'({chsq_pkg::OUT_W{1'b1}});
    assign add_v       = sum_ext + q_ext;
    assign sub_v       = sum_ext - q_ext;
    assign miss        = missing_reg || (at_first_reg && in.sent);

    always_comb begin
        sum_upd = sum_reg;
        ovf_upd = overflow_reg;
        if (!miss && !in.zero) begin
            if (!in.neg) begin
                if (add_v > sum_max_ext) begin
                    sum_upd = {SUM_WIDTH{1'b1}};
                    ovf_upd = 1'b1;
                end else begin
                    sum_upd = add_v[SUM_WIDTH-1:0];
                end
            end else begin
                // Negative terms clamp at zero and never set the overflow flag.
                if (q_ext > sum_ext) begin
                    sum_upd = '0;
                end else begin
                    sum_upd = sub_v[SUM_WIDTH-1:0];
                end
            end
        end
    end

    assign upd_ext = EW'(sum_upd);

    always_comb begin
        sum_next        = sum_reg;
        at_first_next   = at_first_reg;
        missing_next    = missing_reg;
        overflow_next   = overflow_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_distance_next = m_distance_reg;
        m_missing_next  = m_missing_reg;
        m_sat_next      = m_sat_reg;
        if (fire) begin
            if (in.last) begin
                sum_next      = '0;
                at_first_next = 1'b1;
                missing_next  = 1'b0;
                overflow_next = 1'b0;
                m_valid_next  = 1'b1;
                if (miss) begin
                    m_distance_next = {chsq_pkg::OUT_W{1'b1}};
                    m_missing_next  = 1'b1;
                    m_sat_next      = 1'b0;
                end else if (upd_ext > out_max_ext) begin
                    m_distance_next = {chsq_pkg::OUT_W{1'b1}};
                    m_missing_next  = 1'b0;
                    m_sat_next      = 1'b1;
                end else begin
                    m_distance_next = upd_ext[chsq_pkg::OUT_W-1:0];
                    m_missing_next  = 1'b0;
                    m_sat_next      = ovf_upd;
                end
            end else begin
                sum_next      = sum_upd;
                at_first_next = 1'b0;
                missing_next  = miss;
                overflow_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            at_first_reg <= 1'b1;
            missing_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            sum_reg      <= sum_next;
            at_first_reg <= at_first_next;
            missing_reg  <= missing_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
        m_distance_reg <= m_distance_next;
        m_missing_reg  <= m_missing_next;
        m_sat_reg      <= m_sat_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_distance         = m_distance_reg;
    assign m_features_missing = m_missing_reg;
    assign m_saturated        = m_sat_reg;

    a_reset_first: assert property (@(posedge aclk) !aresetn |=> at_first_reg && sum_reg == '0)
        else $error("accumulator did not return to the start of a vector after reset");

    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> at_first_reg && !missing_reg && !overflow_reg && sum_reg == '0)
        else $error("vector state not cleared after a result");

    a_missing_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_missing_reg |-> !m_sat_reg && (&m_distance_reg))
        else $error("missing result must be all ones and not saturated");

    a_missing_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        missing_reg |-> !at_first_reg)
        else $error("missing flag set while still at the first pair");

endmodule

[design/chi_squared_histogram_distance_core.sv]
// Chi-squared histogram distance: accumulates (a-b)^2/|a+b| over a streamed vector of bin pairs.
// Pair throughput is one per clock unless a held result stalls it. Each pair passes two input stages
// (difference, then square), a chain of 35 division cells that each resolve one quotient bit, and
// the accumulator cell, whose output register holds the result. The whole pipeline, input included,
// holds while a finished result waits for m_ready. A run whose first pair carries a -1.0 bin
// returns all ones with features_missing set; an overflowing sum clamps and returns saturated.
// Uses chsq_pkg, chsq_front, chsq_div_cell and chsq_accum.
module chi_squared_histogram_distance_core #(
    parameter int SUM_WIDTH = chsq_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [chsq_pkg::BIN_W-1:0]     s_first_bin,
    input  logic signed [chsq_pkg::BIN_W-1:0]     s_second_bin,
    input  logic                                  s_last_bin,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [chsq_pkg::OUT_W-1:0]            m_distance,
    output logic                                  m_features_missing,
    output logic                                  m_saturated
);

    chsq_pkg::chsq_cell_t chain [0:chsq_pkg::SQ_W];
    logic                 en;

    // Everything advances together unless a result is waiting and not taken.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    chsq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .first_bin  (s_first_bin),
        .second_bin (s_second_bin),
        .last_bin   (s_last_bin),
        .out        (chain[0])
    );

    for (genvar i = 0; i < chsq_pkg::SQ_W; i++) begin : g_cell
        chsq_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in      (chain[i]),
            .out     (chain[i+1])
        );
    end

    chsq_accum #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_accum (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (en),
        .in                 (chain[chsq_pkg::SQ_W]),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_distance         (m_distance),
        .m_features_missing (m_features_missing),
        .m_saturated        (m_saturated)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for chi_squared_histogram_distance_core: streams bin pairs with bursty
// input and a stalling output, predicts each vector's distance and compares every result.
// Depends on chsq_pkg and the core with its submodules.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_WIDTH = chsq_pkg::SUM_WIDTH_DEFAULT;
    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SUM_WIDTH);
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_ITEMS = 625;

    typedef logic signed [chsq_pkg::BIN_W-1:0] bin_t;

    localparam bin_t BIN_MAX = 17'sd65535;

    typedef struct packed {
        logic [chsq_pkg::OUT_W-1:0] distance;
        logic                       missing;
        logic                       saturated;
    } distance_result_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_t;
    typedef enum int {BINS_DENSE, BINS_SPARSE, BINS_RAW, BINS_NEGATIVE} bin_style_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    bin_t                       s_first_bin = '0;
    bin_t                       s_second_bin = '0;
    logic                       s_last_bin = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [chsq_pkg::OUT_W-1:0] m_distance;
    logic                       m_features_missing;
    logic                       m_saturated;

    // Predictor state for the vector currently being streamed.
    longint unsigned  dist_sum = 0;
    bit               first_pair_pending = 1'b1;
    bit               vec_missing = 1'b0;
    bit               sum_clamped = 1'b0;

    distance_result_t expected_distances[$];
    int               mismatches = 0;
    int               items_sent = 0;
    int               rx_hold_cycles = 0;
    int               burst_left = 0;
    bit               tx_bursty = 1'b1;

    chi_squared_histogram_distance_core #(
        .SUM_WIDTH(SUM_WIDTH)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_bin        (s_first_bin),
        .s_second_bin       (s_second_bin),
        .s_last_bin         (s_last_bin),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_distance         (m_distance),
        .m_features_missing (m_features_missing),
        .m_saturated        (m_saturated)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // Updates the running chi-squared sum for one accepted pair and, on the final
    // pair of a vector, queues the distance the core must report.
    function automatic void accept_pair(bin_t a, bin_t b, logic last);
        longint           sa, sb, diff, total;
        longint unsigned  quot;
        distance_result_t res;
        sa = a;
        sb = b;
        if (first_pair_pending &&
            (a == chsq_pkg::SENTINEL_BIN || b == chsq_pkg::SENTINEL_BIN))
            vec_missing = 1'b1;
        first_pair_pending = 1'b0;
        if (!vec_missing) begin
            diff  = sa - sb;
            total = sa + sb;
            if (total != 0) begin
                quot = longint'(diff * diff) / ((total < 0) ? -total : total);
                if (total > 0) begin
                    if (quot > SUM_MAX - dist_sum) begin
                        dist_sum    = SUM_MAX;
                        sum_clamped = 1'b1;
                    end else begin
                        dist_sum += quot;
                    end
                end else if (quot > dist_sum) begin
                    dist_sum = 0;
                end else begin
                    dist_sum -= quot;
                end
            end
        end
        if (last) begin
            if (vec_missing)
                res = '{distance: '1, missing: 1'b1, saturated: 1'b0};
            else if (dist_sum > 64'hFFFF_FFFF)
                res = '{distance: '1, missing: 1'b0, saturated: 1'b1};
            else
                res = '{distance: dist_sum[chsq_pkg::OUT_W-1:0], missing: 1'b0,
                        saturated: sum_clamped};
            expected_distances.push_back(res);
            dist_sum           = 0;
            first_pair_pending = 1'b1;
            vec_missing        = 1'b0;
            sum_clamped        = 1'b0;
        end
    endfunction

    // Starts and ends on a falling edge. Valid stays high into the next call unless a gap
    // is inserted here or the caller drains.
    task automatic send_pair(input bin_t a, input bin_t b, input logic last);
        int gap;
        s_valid      <= 1'b1;
        s_first_bin  <= a;
        s_second_bin <= b;
        s_last_bin   <= last;
        do @(posedge aclk); while (!s_ready);
        accept_pair(a, b, last);
        items_sent++;
        @(negedge aclk);
        if (tx_bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_distances.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic bin_t random_bin(bin_style_t style);
        bin_t v;
        case (style)
            BINS_DENSE:    v = bin_t'($urandom_range(0, 65535));
            BINS_SPARSE:   v = bin_t'($urandom_range(0, 1023));
            BINS_NEGATIVE: begin
                v = bin_t'($urandom_range(1, 65535));
                v = -v;
            end
            default:       v = bin_t'($urandom_range(0, 131071));
        endcase
        return v;
    endfunction

    task automatic send_random_vector(input bit short_vec);
        int         len, pick;
        bin_style_t style;
        bin_t       a, b;
        if (short_vec)
            len = $urandom_range(1, 4);
        else
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        // Mostly nonnegative histograms, with some raw noise and negative bins mixed in.
        style = (pick < 6) ? BINS_DENSE : (pick < 8) ? BINS_SPARSE :
                (pick < 9) ? BINS_RAW : BINS_NEGATIVE;
        for (int i = 0; i < len; i++) begin
            a = random_bin(style);
            b = random_bin(style);
            if (i == 0 && $urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1)) a = chsq_pkg::SENTINEL_BIN;
                else b = chsq_pkg::SENTINEL_BIN;
            end else if ($urandom_range(0, 19) == 0) begin
                b = -a;
            end else if (i > 0 && $urandom_range(0, 29) == 0) begin
                a = chsq_pkg::SENTINEL_BIN;
            end
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic test_basic_terms();
        send_pair(0, 0, 1'b1);
        send_pair(1, 0, 1'b0);
        send_pair(0, 1, 1'b0);
        send_pair(BIN_MAX, BIN_MAX, 1'b1);
        send_pair(BIN_MAX, 0, 1'b1);
        send_pair(1000, 0, 1'b0);
        send_pair(-100, -300, 1'b1);
        send_pair(-100, -300, 1'b1);
        wait_drained();
    endtask

    task automatic test_missing_vectors();
        send_pair(chsq_pkg::SENTINEL_BIN, 5, 1'b0);
        send_pair(7, 7, 1'b0);
        send_pair(1, 2, 1'b1);
        send_pair(3, chsq_pkg::SENTINEL_BIN, 1'b1);
        send_pair(chsq_pkg::SENTINEL_BIN, chsq_pkg::SENTINEL_BIN, 1'b1);
        // A sentinel after the first pair is just a large negative bin.
        send_pair(10, 20, 1'b0);
        send_pair(chsq_pkg::SENTINEL_BIN, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_overflow_and_clamp();
        send_pair(BIN_MAX, -65534, 1'b1);
        send_pair(BIN_MAX, -65534, 1'b0);
        send_pair(-65535, 65534, 1'b1);
        send_pair(BIN_MAX, -65535, 1'b1);
        send_pair(BIN_MAX, 0, 1'b0);
        send_pair(0, -65535, 1'b1);
        send_pair(-1, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_vectors();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            send_random_vector(1'b0);
            // Now and then let every result come back before going on.
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        wait_drained();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_full_pipeline_stall();
        int start;
        tx_bursty = 1'b0;
        @(posedge aclk);
        rx_hold_cycles = 400;
        @(negedge aclk);
        start = items_sent;
        while (items_sent - start < 100) send_random_vector(1'b1);
        wait_drained();
        tx_bursty = 1'b1;
    endtask

    initial begin : ready_pattern
        int       seg_left, tick;
        rx_mode_t mode;
        seg_left = 0;
        tick = 0;
        mode = RX_OPEN;
        forever begin
            @(negedge aclk);
            tick++;
            if (seg_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(40, 200);
            end
            seg_left--;
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:     m_ready <= 1'b1;
                    RX_RANDOM:   m_ready <= ($urandom_range(0, 2) != 0);
                    RX_PERIODIC: m_ready <= ((tick % 9) >= 4);
                    default:     m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        distance_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_distances.size() == 0) begin
                $display("%0t: unexpected transaction, distance %h missing %b saturated %b",
                         $time, m_distance, m_features_missing, m_saturated);
                mismatches++;
            end else begin
                want = expected_distances.pop_front();
                if (m_distance !== want.distance) begin
                    $display("%0t: distance expected %h actual %h",
                             $time, want.distance, m_distance);
                    mismatches++;
                end
                if (m_features_missing !== want.missing) begin
                    $display("%0t: features_missing expected %b actual %b",
                             $time, want.missing, m_features_missing);
                    mismatches++;
                end
                if (m_saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, m_saturated);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, expected_distances.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : main_sequence
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_terms();
        test_missing_vectors();
        test_overflow_and_clamp();
        test_full_pipeline_stall();
        test_random_vectors();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_distances.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[chi_squared_histogram_distance_core.f]
design/chsq_pkg.sv
design/chsq_front.sv
design/chsq_div_cell.sv
design/chsq_accum.sv
design/chi_squared_histogram_distance_core.sv
sim/testbench.sv
